// File: hdl/rec_pkg.sv
// shared types, constants and segment decode for the rotary encoder counter
package rec_pkg;

    localparam int COUNT_W     = 10;
    localparam int SAMPLE_W    = 8;
    localparam int STEP_W      = 3;
    localparam int SEG_W       = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAYLOAD_W = COUNT_W + 4 * SEG_W;

    localparam logic [STEP_W-1:0]   STEP_RESET = 3'd1;

    localparam logic [SAMPLE_W-1:0] LEFT_DETENT  = 8'hFD;
    localparam logic [SAMPLE_W-1:0] RIGHT_DETENT = 8'hF7;
    localparam logic [SAMPLE_W-1:0] LEFT_UP_PREV  = 8'hFC;
    localparam logic [SAMPLE_W-1:0] RIGHT_UP_PREV = 8'hF3;
    localparam logic [SAMPLE_W-1:0] DOWN_PREV     = 8'hFF;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } rec_beat_t;

    // active-low segments a..g in bits 0..6, dp off
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/rec_counter.sv
// detent decode, up/down counter state and count stage register
module rec_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rec_pkg::STEP_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    input  logic [rec_pkg::SAMPLE_W-1:0]      in_sample,
    output logic                              in_ready,
    output rec_pkg::rec_beat_t                beat_out,
    input  logic                              beat_ready
);

    logic [rec_pkg::STEP_W-1:0]   step_reg;
    logic [rec_pkg::SAMPLE_W-1:0] prev_reg;
    logic [rec_pkg::COUNT_W-1:0]  count_reg;
    logic [rec_pkg::COUNT_W-1:0]  count_next;
    rec_pkg::rec_beat_t           beat_reg;
    rec_pkg::rec_beat_t           beat_next;
    logic                         accept;
    logic                         up;
    logic                         down;
    logic [rec_pkg::COUNT_W-1:0]  step_ext;

    assign in_ready = !beat_reg.valid || beat_ready;
    assign accept   = in_valid && in_ready;
    assign beat_out = beat_reg;
    assign step_ext = {{(rec_pkg::COUNT_W - rec_pkg::STEP_W){1'b0}}, step_reg};

    always_comb begin
        up   = 1'b0;
        down = 1'b0;
        if (in_sample == rec_pkg::LEFT_DETENT) begin
            up   = (prev_reg == rec_pkg::LEFT_UP_PREV);
            down = (prev_reg == rec_pkg::DOWN_PREV);
        end else if (in_sample == rec_pkg::RIGHT_DETENT) begin
            up   = (prev_reg == rec_pkg::RIGHT_UP_PREV);
            down = (prev_reg == rec_pkg::DOWN_PREV);
        end

        // 10-bit add and subtract wrap modulo 1024 by themselves
        count_next = count_reg;
        if (up) begin
            count_next = count_reg + step_ext;
        end else if (down) begin
            count_next = count_reg - step_ext;
        end

        beat_next = beat_reg;
        if (accept) begin
            beat_next.valid = 1'b1;
            beat_next.count = count_next;
        end else if (beat_ready) begin
            beat_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= rec_pkg::STEP_RESET;
            prev_reg       <= '0;
            count_reg      <= '0;
            beat_reg.valid <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (accept) begin
                prev_reg  <= in_sample;
                count_reg <= count_next;
            end
            beat_reg.valid <= beat_next.valid;
        end
        beat_reg.count <= beat_next.count;
    end

endmodule

// File: hdl/rec_display.sv
// decimal digit split, segment encode and output register
module rec_display (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rec_pkg::rec_beat_t                beat_in,
    output logic                              beat_ready,
    output logic                              out_valid,
    output logic [rec_pkg::M_PAYLOAD_W-1:0]   out_payload,
    input  logic                              out_ready
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [rec_pkg::M_PAYLOAD_W-1:0]  payload_reg;
    logic [rec_pkg::M_PAYLOAD_W-1:0]  payload_next;

    logic [rec_pkg::COUNT_W-1:0] c;
    logic [17:0]                 by_ten_prod;
    logic [15:0]                 by_hund_prod;
    logic [6:0]                  tens_total;
    logic [3:0]                  hund_total;
    logic [3:0]                  d_ones;
    logic [3:0]                  d_tens;
    logic [3:0]                  d_hund;
    logic [3:0]                  d_thou;
    logic                        ge10;
    logic                        ge100;
    logic                        ge1000;
    logic [rec_pkg::SEG_W-1:0]   s_ones;
    logic [rec_pkg::SEG_W-1:0]   s_tens;
    logic [rec_pkg::SEG_W-1:0]   s_hund;
    logic [rec_pkg::SEG_W-1:0]   s_thou;
    logic [rec_pkg::COUNT_W-1:0] ones_wide;
    logic [6:0]                  tens_wide;
    logic [3:0]                  hund_adj;

    assign beat_ready  = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_payload = payload_reg;

    always_comb begin
        c = beat_in.count;
        // c/10 as c*205 >> 11 and c/100 as c*41 >> 12, exact for c < 1024
        by_ten_prod  = 18'(c) * 18'd205;
        by_hund_prod = 16'(c) * 16'd41;
        tens_total   = by_ten_prod[17:11];
        hund_total   = by_hund_prod[15:12];

        ones_wide = c - 10'(tens_total) * 10'd10;
        tens_wide = tens_total - 7'(hund_total) * 7'd10;
        ge1000    = (c >= 10'd1000);
        hund_adj  = ge1000 ? hund_total - 4'd10 : hund_total;

        d_ones = ones_wide[3:0];
        d_tens = tens_wide[3:0];
        d_hund = hund_adj;
        d_thou = {3'b000, ge1000};
        ge10   = (c >= 10'd10);
        ge100  = (c >= 10'd100);

        s_ones = rec_pkg::seg_code(d_ones);
        s_tens = ge10   ? rec_pkg::seg_code(d_tens) : rec_pkg::SEG_BLANK;
        s_hund = ge100  ? rec_pkg::seg_code(d_hund) : rec_pkg::SEG_BLANK;
        s_thou = ge1000 ? rec_pkg::seg_code(d_thou) : rec_pkg::SEG_BLANK;

        valid_next   = valid_reg;
        payload_next = payload_reg;
        if (beat_ready) begin
            valid_next = beat_in.valid;
            if (beat_in.valid) begin
                payload_next = {s_thou, s_hund, s_tens, s_ones, c};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        payload_reg <= payload_next;
    end

endmodule

// File: hdl/rotary_encoder_counter_display_top.sv
// an accepted sample beat passes the count stage register, then the display output register, before its result is valid
// throughput: one sample per cycle while the result side is not stalled, set by the counter update loop
// a stalled result holds off new samples only once both stage registers are full
// reset: synchronous active-low aresetn clears previous sample and count to 0,
// sets step size to 1 and empties both stages
module rotary_encoder_counter_display_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rec_pkg::STEP_W-1:0]        cfg_wr_data,    // step_size
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rec_pkg::S_TDATA_W-1:0]     s_tdata,        // [7:0] encoder_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] count_value, [17:10] seg_ones, [25:18] seg_tens,
    // [33:26] seg_hundreds, [41:34] seg_thousands, [47:42] zero
    output logic [rec_pkg::M_TDATA_W-1:0]     m_tdata
);

    rec_pkg::rec_beat_t                 count_beat;
    logic                               count_ready;
    logic [rec_pkg::M_PAYLOAD_W-1:0]    payload;

    rec_counter u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_sample   (s_tdata[rec_pkg::SAMPLE_W-1:0]),
        .in_ready    (s_tready),
        .beat_out    (count_beat),
        .beat_ready  (count_ready)
    );

    rec_display u_display (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_in     (count_beat),
        .beat_ready  (count_ready),
        .out_valid   (m_tvalid),
        .out_payload (payload),
        .out_ready   (m_tready)
    );

    assign m_tdata = {{(rec_pkg::M_TDATA_W - rec_pkg::M_PAYLOAD_W){1'b0}}, payload};

endmodule

// File: hdl/rec_checker.sv
// port-level checks for the encoder counter top level, bound to it
module rec_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rec_pkg::M_TDATA_W-1:0] m_tdata
);

    // results stay put while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // thousands digit shown exactly when count reaches 1000
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[9:0] >= 10'd1000) == (m_tdata[41:34] != rec_pkg::SEG_BLANK)))
        else $error("thousands blanking does not match count");

    // tens digit blanked below 10, shown otherwise
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[9:0] < 10'd10) == (m_tdata[25:18] == rec_pkg::SEG_BLANK)))
        else $error("tens blanking does not match count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:42] == 6'd0))
        else $error("padding bits of result beat not zero");

endmodule

bind rotary_encoder_counter_display_top rec_checker u_rec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/rotary_encoder_counter_display_top_tb.sv
// self-checking bench for the rotary encoder counter with seven-segment digit codes
`timescale 1ns / 100ps

module rotary_encoder_counter_display_top_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_SAMPLES = 219;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_REPORTS   = 10;

    // same bit layout as m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]                  pad;
        logic [rec_pkg::SEG_W-1:0]   thousands;
        logic [rec_pkg::SEG_W-1:0]   hundreds;
        logic [rec_pkg::SEG_W-1:0]   tens;
        logic [rec_pkg::SEG_W-1:0]   ones;
        logic [rec_pkg::COUNT_W-1:0] count;
    } display_t;

    typedef struct {
        logic [rec_pkg::SAMPLE_W-1:0] smp;
        bit                           typed;
        display_t                     want;
    } sample_row_t;

    localparam logic [rec_pkg::SEG_W-1:0] DIGIT_SEG [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [rec_pkg::STEP_W-1:0]      cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rec_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [rec_pkg::M_TDATA_W-1:0]   m_tdata;

    // predictor state
    logic [rec_pkg::SAMPLE_W-1:0]    last_sample;
    logic [rec_pkg::COUNT_W-1:0]     count_now;
    logic [rec_pkg::STEP_W-1:0]      step_now;

    display_t               pending_display[$];
    int                     tx_gap_pct;
    int                     rx_stall_pct;
    int                     cycles;
    int                     mismatches;
    int                     results_seen;
    int                     samples_sent;
    int                     steps_up;
    int                     steps_down;
    int                     wraps;

    rotary_encoder_counter_display_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic display_t decode_display(input int c);
        display_t d;
        d = '0;
        d.count     = c[rec_pkg::COUNT_W-1:0];
        d.ones      = DIGIT_SEG[c % 10];
        d.tens      = (c >= 10)   ? DIGIT_SEG[(c / 10) % 10]  : rec_pkg::SEG_BLANK;
        d.hundreds  = (c >= 100)  ? DIGIT_SEG[(c / 100) % 10] : rec_pkg::SEG_BLANK;
        d.thousands = (c >= 1000) ? DIGIT_SEG[c / 1000]       : rec_pkg::SEG_BLANK;
        return d;
    endfunction

    // moves the counter for one sample and returns the display it should show
    function automatic display_t advance_counter(input logic [rec_pkg::SAMPLE_W-1:0] smp);
        bit go_up;
        bit go_down;
        int c;
        go_up   = 1'b0;
        go_down = 1'b0;
        if (smp == rec_pkg::LEFT_DETENT) begin
            go_up   = (last_sample == rec_pkg::LEFT_UP_PREV);
            go_down = (last_sample == rec_pkg::DOWN_PREV);
        end else if (smp == rec_pkg::RIGHT_DETENT) begin
            go_up   = (last_sample == rec_pkg::RIGHT_UP_PREV);
            go_down = (last_sample == rec_pkg::DOWN_PREV);
        end
        c = count_now;
        if (go_up) begin
            c = (c + step_now) % 1024;
            steps_up++;
            if (c < count_now) wraps++;
        end else if (go_down) begin
            c = (c + 1024 - step_now) % 1024;
            steps_down++;
            if (c > count_now) wraps++;
        end
        count_now   = c[rec_pkg::COUNT_W-1:0];
        last_sample = smp;
        return decode_display(c);
    endfunction

    task automatic push_sample(input logic [rec_pkg::SAMPLE_W-1:0] smp);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        pending_display.push_back(advance_counter(smp));
        samples_sent++;
    endtask

    // only written with nothing in flight
    task automatic set_step(input logic [rec_pkg::STEP_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_display.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        step_now = value;
    endtask

    task automatic run_phase(input int n_samples, input bit drift_up);
        int  start;
        int  r;
        bit  up;
        logic [rec_pkg::SAMPLE_W-1:0] detent;
        start = samples_sent;
        while (samples_sent - start < n_samples) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // well-formed detent: lead-in byte then the detent byte
                up = ($urandom_range(0, 99) < 80) ? drift_up : !drift_up;
                if ($urandom_range(0, 1)) begin
                    push_sample(up ? rec_pkg::LEFT_UP_PREV : rec_pkg::DOWN_PREV);
                    push_sample(rec_pkg::LEFT_DETENT);
                end else begin
                    push_sample(up ? rec_pkg::RIGHT_UP_PREV : rec_pkg::DOWN_PREV);
                    push_sample(rec_pkg::RIGHT_DETENT);
                end
            end else if (r < 85) begin
                push_sample(8'($urandom_range(0, 255)));
            end else begin
                detent = $urandom_range(0, 1) ? rec_pkg::LEFT_DETENT : rec_pkg::RIGHT_DETENT;
                case ($urandom_range(0, 3))
                    0: begin
                        push_sample(rec_pkg::DOWN_PREV);
                        push_sample(8'($urandom_range(0, 255)));
                    end
                    1: push_sample(detent);
                    // lead-in of the other encoder
                    2: begin
                        push_sample(detent == rec_pkg::LEFT_DETENT ?
                                    rec_pkg::RIGHT_UP_PREV : rec_pkg::LEFT_UP_PREV);
                        push_sample(detent);
                    end
                    default: begin
                        push_sample($urandom_range(0, 1) ?
                                    rec_pkg::LEFT_UP_PREV : rec_pkg::RIGHT_UP_PREV);
                        push_sample(detent ^ (8'h01 << $urandom_range(0, 7)));
                    end
                endcase
            end
        end
    endtask

    // result side back-pressure
    initial begin
        m_tready <= 1'b0;
        forever begin
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    initial begin
        display_t got;
        display_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (pending_display.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: count %0d data %h",
                                 got.count, m_tdata);
                end else begin
                    want = pending_display.pop_front();
                    if (got.count !== want.count || got.ones !== want.ones ||
                        got.tens !== want.tens || got.hundreds !== want.hundreds ||
                        got.thousands !== want.thousands || got.pad !== want.pad) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d: exp count %0d seg %h %h %h %h pad %h,",
                                      " got count %0d seg %h %h %h %h pad %h"},
                                     results_seen, want.count, want.thousands,
                                     want.hundreds, want.tens, want.ones, want.pad,
                                     got.count, got.thousands, got.hundreds,
                                     got.tens, got.ones, got.pad);
                    end
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d results still due",
                         cycles, pending_display.size());
                $display("rotary_encoder_counter_display_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        sample_row_t rows[24];
        logic [rec_pkg::STEP_W-1:0] phase_step[NUM_PHASES];
        int gap_pct[NUM_PHASES];
        int stall_pct[NUM_PHASES];
        int i;

        rows = '{
            '{8'h00, 1'b1, decode_display(0)},     // right after reset
            '{8'hFF, 1'b0, '0},
            '{8'hFD, 1'b1, decode_display(1023)},  // left down wraps below zero
            '{8'hFC, 1'b0, '0},
            '{8'hFD, 1'b1, decode_display(0)},     // left up wraps past the top
            '{8'hF3, 1'b0, '0},
            '{8'hF7, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hF7, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hF7, 1'b1, decode_display(1023)},  // right down wraps
            '{8'hF3, 1'b0, '0},
            '{8'hF7, 1'b1, decode_display(0)},
            '{8'hFC, 1'b0, '0},
            '{8'hF7, 1'b0, '0},                    // left lead-in, right detent
            '{8'hF3, 1'b0, '0},
            '{8'hFD, 1'b0, '0},                    // right lead-in, left detent
            '{8'hFD, 1'b0, '0},
            '{8'hF7, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFD, 1'b1, decode_display(1023)},
            '{8'h55, 1'b0, '0},
            '{8'hAA, 1'b0, '0}
        };
        phase_step = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd1};
        gap_pct    = '{15, 30, 0, 20, 40, 10, 25, 0};
        stall_pct  = '{20, 0, 35, 15, 40, 10, 25, 0};

        mismatches   = 0;
        results_seen = 0;
        samples_sent = 0;
        steps_up     = 0;
        steps_down   = 0;
        wraps        = 0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        last_sample  = '0;
        count_now    = '0;
        step_now     = rec_pkg::STEP_RESET;

        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        for (i = 0; i < 24; i++) begin
            push_sample(rows[i].smp);
            if (rows[i].typed)
                pending_display[pending_display.size() - 1] = rows[i].want;
        end

        for (i = 0; i < NUM_PHASES; i++) begin
            set_step(phase_step[i]);
            tx_gap_pct   = gap_pct[i];
            rx_stall_pct = stall_pct[i];
            run_phase(PHASE_SAMPLES, 1'($urandom_range(0, 1)));
        end

        s_tvalid <= 1'b0;
        while (pending_display.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);

        $display("%0d samples sent, %0d results checked, step sizes 0..7", samples_sent,
                 results_seen);
        $display("counter moved up %0d and down %0d times, %0d wraps", steps_up,
                 steps_down, wraps);
        if (mismatches == 0) begin
            $display("rotary_encoder_counter_display_top: match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rotary_encoder_counter_display_top: mismatch");
        end
        $finish;
    end

endmodule
